// ===== hw/rtl/grit_pkg.sv =====
// ----------------------------------------------------------------------------
// Group range index table package
// Shared widths, command and status codes, controller operations and the
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package grit_pkg;

	localparam int GROUPS     = 256;
	localparam int ADDR_W     = 8;
	localparam int CNT_W      = 9;
	localparam int ITEM_W     = 16;
	localparam int RANK_W     = 8;
	localparam int MAP_W      = 17;
	localparam int ENTRY_W    = 2 * ITEM_W + RANK_W;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 104;

	// Input commands
	localparam logic [2:0] CMD_CLEAR     = 3'd0;
	localparam logic [2:0] CMD_APPEND    = 3'd1;
	localparam logic [2:0] CMD_SET_SIZE  = 3'd2;
	localparam logic [2:0] CMD_ITEM_LOOK = 3'd3;
	localparam logic [2:0] CMD_GRP_LOOK  = 3'd4;
	localparam logic [2:0] CMD_TO_LAYOUT = 3'd5;
	localparam logic [2:0] CMD_TO_DATA   = 3'd6;

	// Result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	// Datapath operations issued by the controller
	localparam logic [4:0] OP_NONE      = 5'd0;
	localparam logic [4:0] OP_LATCH     = 5'd1;
	localparam logic [4:0] OP_CLEAR     = 5'd2;
	localparam logic [4:0] OP_APPEND    = 5'd3;
	localparam logic [4:0] OP_REJECT    = 5'd4;
	localparam logic [4:0] OP_MISS      = 5'd5;
	localparam logic [4:0] OP_PASS      = 5'd6;
	localparam logic [4:0] OP_RD_IDX    = 5'd7;
	localparam logic [4:0] OP_SZ_CHECK  = 5'd8;
	localparam logic [4:0] OP_RD_PTR    = 5'd9;
	localparam logic [4:0] OP_REB_WRITE = 5'd10;
	localparam logic [4:0] OP_REB_END   = 5'd11;
	localparam logic [4:0] OP_SRCH_INIT = 5'd12;
	localparam logic [4:0] OP_RD_MID    = 5'd13;
	localparam logic [4:0] OP_SRCH_STEP = 5'd14;
	localparam logic [4:0] OP_RD_LO     = 5'd15;
	localparam logic [4:0] OP_MAP_LO    = 5'd16;
	localparam logic [4:0] OP_GRP_RES   = 5'd17;
	localparam logic [4:0] OP_ITEM_RES  = 5'd18;
	localparam logic [4:0] OP_LAY_RES   = 5'd19;
	localparam logic [4:0] OP_PUSH      = 5'd20;

	typedef struct packed {
		logic [4:0] op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       hide;
		logic       idx_lt_gt;
		logic       app_ok;
		logic       item_ok;
		logic       conv_go;
		logic       search_go;
		logic       reb_go;
		logic       sz_ok;
		logic       out_free;
	} dp_status_t;

endpackage

// ===== hw/rtl/group_range_index_table_unit.sv =====
// ----------------------------------------------------------------------------
// Group range index table unit
// Table of consecutive item groups with append, resize, item and group
// lookup by binary search, and data/layout header index conversion.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Beat contents
//  s_*       | in        | command, index, size
//  m_*       | out       | status, group_index, index_in_group, group_start,
//            |           | group_items, mapped_index, total_items, layout_groups
//  cfg_*     | in        | hide_empty, one bit, written on cfg_we
//
// One command is in flight at a time; s_tready is high only while idle.
// Clear, append and pass-through conversions go through DISPATCH and FINISH to
// the output register; group lookup and to-layout also pass G_WAIT or L_WAIT.
// Lookups run a binary search on the table RAM's registered read port, each
// step a read state and a compare state; item lookup then reads the found
// group before FINISH, a read that to-data skips.
// Set size rewrites the indexed group and each following group in turn.
// A finished result waits in the output register while the next beat is
// taken. Reset clears the totals; table entries are written before use.
module group_range_index_table_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [2:0] command, [18:3] index, [34:19] size, zero above
	input  logic [grit_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [1:0] status, [9:2] group_index, [25:10] index_in_group,
	// [41:26] group_start, [57:42] group_items, [74:58] mapped_index,
	// [90:75] total_items, [99:91] layout_groups, zero above
	output logic [grit_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic                                cfg_wdata
);

	grit_pkg::ctrl_cmd_t  ctl;
	grit_pkg::dp_status_t st;
	logic                 hide_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hide_q <= 1'b0;
		end else if (cfg_we) begin
			hide_q <= cfg_wdata;
		end
	end

	grit_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.st      (st),
		.ctl     (ctl)
	);

	grit_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.st       (st),
		.in_data  (s_tdata),
		.hide     (hide_q),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata)
	);

endmodule

// ===== hw/rtl/grit_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module grit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/grit_ctrl.sv =====
// ----------------------------------------------------------------------------
// Group range index table controller
// Sequences each command into datapath operations: table reads, searches,
// range rebuilds and the final result beat.
// ----------------------------------------------------------------------------
module grit_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  grit_pkg::dp_status_t st,
	output grit_pkg::ctrl_cmd_t  ctl
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DISPATCH  = 4'd1;
	localparam logic [3:0] S_SZ_WAIT   = 4'd2;
	localparam logic [3:0] S_REB_RD    = 4'd3;
	localparam logic [3:0] S_REB_WR    = 4'd4;
	localparam logic [3:0] S_SRCH      = 4'd5;
	localparam logic [3:0] S_SRCH_WAIT = 4'd6;
	localparam logic [3:0] S_G_WAIT    = 4'd7;
	localparam logic [3:0] S_G3_WAIT   = 4'd8;
	localparam logic [3:0] S_L_WAIT    = 4'd9;
	localparam logic [3:0] S_FINISH    = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and operation select.
	always_comb begin
		state_d = state_q;
		ctl.op  = grit_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.op  = grit_pkg::OP_LATCH;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_FINISH;
				unique case (st.cmd)
					grit_pkg::CMD_CLEAR: begin
						ctl.op = grit_pkg::OP_CLEAR;
					end
					grit_pkg::CMD_APPEND: begin
						ctl.op = st.app_ok ? grit_pkg::OP_APPEND : grit_pkg::OP_REJECT;
					end
					grit_pkg::CMD_SET_SIZE: begin
						if (st.idx_lt_gt) begin
							ctl.op  = grit_pkg::OP_RD_IDX;
							state_d = S_SZ_WAIT;
						end else begin
							ctl.op = grit_pkg::OP_MISS;
						end
					end
					grit_pkg::CMD_ITEM_LOOK: begin
						if (st.item_ok) begin
							ctl.op  = grit_pkg::OP_SRCH_INIT;
							state_d = S_SRCH;
						end else begin
							ctl.op = grit_pkg::OP_MISS;
						end
					end
					grit_pkg::CMD_GRP_LOOK: begin
						if (st.idx_lt_gt) begin
							ctl.op  = grit_pkg::OP_RD_IDX;
							state_d = S_G_WAIT;
						end else begin
							ctl.op = grit_pkg::OP_MISS;
						end
					end
					grit_pkg::CMD_TO_LAYOUT: begin
						if (st.hide && st.idx_lt_gt) begin
							ctl.op  = grit_pkg::OP_RD_IDX;
							state_d = S_L_WAIT;
						end else begin
							ctl.op = grit_pkg::OP_PASS;
						end
					end
					grit_pkg::CMD_TO_DATA: begin
						if (st.conv_go) begin
							ctl.op  = grit_pkg::OP_SRCH_INIT;
							state_d = S_SRCH;
						end else begin
							ctl.op = grit_pkg::OP_PASS;
						end
					end
					default: begin
						ctl.op = grit_pkg::OP_NONE;
					end
				endcase
			end
			S_SZ_WAIT: begin
				ctl.op  = grit_pkg::OP_SZ_CHECK;
				state_d = st.sz_ok ? S_REB_RD : S_FINISH;
			end
			S_REB_RD: begin
				if (st.reb_go) begin
					ctl.op  = grit_pkg::OP_RD_PTR;
					state_d = S_REB_WR;
				end else begin
					ctl.op  = grit_pkg::OP_REB_END;
					state_d = S_FINISH;
				end
			end
			S_REB_WR: begin
				ctl.op  = grit_pkg::OP_REB_WRITE;
				state_d = S_REB_RD;
			end
			S_SRCH: begin
				if (st.search_go) begin
					ctl.op  = grit_pkg::OP_RD_MID;
					state_d = S_SRCH_WAIT;
				end else if (st.cmd == grit_pkg::CMD_ITEM_LOOK) begin
					ctl.op  = grit_pkg::OP_RD_LO;
					state_d = S_G3_WAIT;
				end else begin
					ctl.op  = grit_pkg::OP_MAP_LO;
					state_d = S_FINISH;
				end
			end
			S_SRCH_WAIT: begin
				ctl.op  = grit_pkg::OP_SRCH_STEP;
				state_d = S_SRCH;
			end
			S_G_WAIT: begin
				ctl.op  = grit_pkg::OP_GRP_RES;
				state_d = S_FINISH;
			end
			S_G3_WAIT: begin
				ctl.op  = grit_pkg::OP_ITEM_RES;
				state_d = S_FINISH;
			end
			S_L_WAIT: begin
				ctl.op  = grit_pkg::OP_LAY_RES;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (st.out_free) begin
					ctl.op  = grit_pkg::OP_PUSH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/grit_dp.sv =====
// ----------------------------------------------------------------------------
// Group range index table datapath
// Holds the totals, the range table memory, the search and rebuild
// registers, the result registers and the output register.
// ----------------------------------------------------------------------------
module grit_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  grit_pkg::ctrl_cmd_t                 ctl,
	output grit_pkg::dp_status_t                st,
	input  logic [grit_pkg::IN_DATA_W-1:0]      in_data,
	input  logic                                hide,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [grit_pkg::OUT_DATA_W-1:0]     out_data
);

	localparam int IW = grit_pkg::ITEM_W;
	localparam int CW = grit_pkg::CNT_W;
	localparam int AW = grit_pkg::ADDR_W;
	localparam int RW = grit_pkg::RANK_W;
	localparam int MW = grit_pkg::MAP_W;
	localparam logic [CW-1:0] GroupsMax = CW'(grit_pkg::GROUPS);
	localparam logic [IW:0]   ItemLimit = {1'b0, {IW{1'b1}}};

	// Latched command fields
	logic [2:0]    cmd_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] size_q;

	// Table totals
	logic [CW-1:0] gt_q;
	logic [IW-1:0] it_q;
	logic [CW-1:0] nt_q;

	// Search and rebuild registers
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] ptr_q;
	logic [IW-1:0] pos_q;
	logic [CW-1:0] rank_q;
	logic          first_q;

	// Result registers
	logic [1:0]           res_status_q;
	logic [RW-1:0]        res_gidx_q;
	logic [IW-1:0]        res_ing_q;
	logic [IW-1:0]        res_gstart_q;
	logic [IW-1:0]        res_gitems_q;
	logic signed [MW-1:0] res_mapped_q;

	logic                 out_valid_q;
	logic [grit_pkg::OUT_DATA_W-1:0] out_data_q;

	// Table memory port signals
	logic                             ram_we;
	logic [AW-1:0]                    ram_waddr;
	logic [grit_pkg::ENTRY_W-1:0]     ram_wdata;
	logic [AW-1:0]                    ram_raddr;
	logic [grit_pkg::ENTRY_W-1:0]     ram_rdata;
	logic [IW-1:0]                    rd_start;
	logic [IW-1:0]                    rd_end;
	logic [RW-1:0]                    rd_rank;
	logic [IW-1:0]                    rd_items;

	logic [CW-1:0]        mid;
	logic [IW:0]          app_sum;
	logic [IW:0]          sz_sum;
	logic [IW-1:0]        reb_sz;
	logic [IW-1:0]        search_key;
	logic signed [MW-1:0] cap;
	logic signed [MW-1:0] rank_ext;
	logic [CW-1:0]        layout;

	assign rd_start = ram_rdata[IW-1:0];
	assign rd_end   = ram_rdata[2*IW-1:IW];
	assign rd_rank  = ram_rdata[grit_pkg::ENTRY_W-1:2*IW];
	assign rd_items = rd_end - rd_start;

	assign mid        = lo_q + ((hi_q - lo_q) >> 1);
	assign app_sum    = {1'b0, it_q} + {1'b0, size_q};
	assign sz_sum     = {1'b0, it_q - rd_items} + {1'b0, size_q};
	assign reb_sz     = first_q ? size_q : rd_items;
	assign search_key = (cmd_q == grit_pkg::CMD_ITEM_LOOK) ? rd_end : {{(IW-RW){1'b0}}, rd_rank};
	assign cap        = $signed({{(MW-CW){1'b0}}, nt_q}) - MW'(1);
	assign rank_ext   = $signed({{(MW-RW){1'b0}}, rd_rank});
	assign layout     = hide ? nt_q : gt_q;

	// Status toward the controller.
	always_comb begin
		st.cmd       = cmd_q;
		st.hide      = hide;
		st.idx_lt_gt = idx_q < {{(IW-CW){1'b0}}, gt_q};
		st.app_ok    = (gt_q < GroupsMax) && (app_sum <= ItemLimit);
		st.item_ok   = (gt_q != '0) && (idx_q < it_q);
		st.conv_go   = hide && (gt_q != nt_q);
		st.search_go = lo_q < hi_q;
		st.reb_go    = ptr_q < gt_q;
		st.sz_ok     = sz_sum <= ItemLimit;
		st.out_free  = !out_valid_q || out_ready;
	end

	// Table memory address and write data selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = gt_q[AW-1:0];
		ram_wdata = {nt_q[RW-1:0], app_sum[IW-1:0], it_q};
		case (ctl.op)
			grit_pkg::OP_RD_MID: ram_raddr = mid[AW-1:0];
			grit_pkg::OP_RD_LO:  ram_raddr = lo_q[AW-1:0];
			grit_pkg::OP_RD_PTR: ram_raddr = ptr_q[AW-1:0];
			default:             ram_raddr = idx_q[AW-1:0];
		endcase
		if (ctl.op == grit_pkg::OP_APPEND) begin
			ram_we = 1'b1;
		end else if (ctl.op == grit_pkg::OP_REB_WRITE) begin
			ram_we    = 1'b1;
			ram_waddr = ptr_q[AW-1:0];
			ram_wdata = {rank_q[RW-1:0], pos_q + reb_sz, pos_q};
		end
	end

	grit_ram #(
		.WIDTH(grit_pkg::ENTRY_W),
		.DEPTH(grit_pkg::GROUPS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Totals and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q        <= '0;
			it_q        <= '0;
			nt_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.op == grit_pkg::OP_PUSH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (ctl.op)
				grit_pkg::OP_CLEAR: begin
					gt_q <= '0;
					it_q <= '0;
					nt_q <= '0;
				end
				grit_pkg::OP_APPEND: begin
					gt_q <= gt_q + CW'(1);
					it_q <= app_sum[IW-1:0];
					nt_q <= nt_q + CW'(size_q != '0);
				end
				grit_pkg::OP_REB_END: begin
					it_q <= pos_q;
					nt_q <= rank_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Command fields, working registers, results and output payload.
	always_ff @(posedge clk) begin
		case (ctl.op)
			grit_pkg::OP_LATCH: begin
				cmd_q        <= in_data[2:0];
				idx_q        <= in_data[18:3];
				size_q       <= in_data[34:19];
				res_status_q <= grit_pkg::ST_OK;
				res_gidx_q   <= '0;
				res_ing_q    <= '0;
				res_gstart_q <= '0;
				res_gitems_q <= '0;
				res_mapped_q <= '0;
			end
			grit_pkg::OP_REJECT: begin
				res_status_q <= grit_pkg::ST_REJECT;
			end
			grit_pkg::OP_MISS: begin
				res_status_q <= grit_pkg::ST_RANGE;
			end
			grit_pkg::OP_PASS: begin
				res_mapped_q <= $signed({1'b0, idx_q});
			end
			grit_pkg::OP_SZ_CHECK: begin
				if (sz_sum > ItemLimit) begin
					res_status_q <= grit_pkg::ST_REJECT;
				end
				pos_q   <= rd_start;
				rank_q  <= {1'b0, rd_rank};
				ptr_q   <= idx_q[CW-1:0];
				first_q <= 1'b1;
			end
			grit_pkg::OP_REB_WRITE: begin
				pos_q   <= pos_q + reb_sz;
				rank_q  <= rank_q + CW'(reb_sz != '0);
				ptr_q   <= ptr_q + CW'(1);
				first_q <= 1'b0;
			end
			grit_pkg::OP_SRCH_INIT: begin
				lo_q <= '0;
				hi_q <= gt_q;
			end
			grit_pkg::OP_SRCH_STEP: begin
				if (idx_q < search_key) begin
					hi_q <= mid;
				end else begin
					lo_q <= mid + CW'(1);
				end
			end
			grit_pkg::OP_MAP_LO: begin
				res_mapped_q <= $signed({{(MW-CW){1'b0}}, lo_q}) - MW'(1);
			end
			grit_pkg::OP_GRP_RES: begin
				res_gstart_q <= rd_start;
				res_gitems_q <= rd_items;
			end
			grit_pkg::OP_ITEM_RES: begin
				if (lo_q < gt_q) begin
					res_gidx_q   <= lo_q[RW-1:0];
					res_gstart_q <= rd_start;
					res_gitems_q <= rd_items;
					res_ing_q    <= idx_q - rd_start;
				end else begin
					res_status_q <= grit_pkg::ST_RANGE;
				end
			end
			grit_pkg::OP_LAY_RES: begin
				res_mapped_q <= (rank_ext > cap) ? cap : rank_ext;
			end
			grit_pkg::OP_PUSH: begin
				out_data_q <= {4'b0, layout, it_q, res_mapped_q, res_gitems_q,
					res_gstart_q, res_ing_q, res_gidx_q, res_status_q};
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== hw/rtl/grit_checker.sv =====
// ----------------------------------------------------------------------------
// Group range index table port checker
// Port-level assertions on beat ordering and result fields.
// ----------------------------------------------------------------------------
module grit_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata
);

	// A result beat stays offered until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped before acceptance");

	// Only one command is taken at a time.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a command is in flight");

	// Status is never the unused code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'd3))
		else $error("status field holds an unused code");

	// Layout group count never exceeds the table depth.
	a_layout: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[99] |-> (m_tdata[98:91] == 8'd0))
		else $error("layout group count beyond table depth");

endmodule

bind group_range_index_table_unit grit_checker u_grit_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
